FILE: rtl/csia_pkg.sv
// shared types, codes and helpers for the checked signed integer alu
package csia_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned StepCount = 64;

   // operation codes
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_MOD = 3'd4;
   localparam logic [2:0] OP_CAT = 3'd5;

   // status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_INVALID  = 2'd3
   } csia_status_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [63:0] operand_a;
      logic signed [63:0] operand_b;
   } csia_req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic [1:0]         status;
   } csia_rsp_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_POW,
      S_MUL,
      S_DIV,
      S_FINISH
   } csia_state_type;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SETUP_MUL,
      CMD_SETUP_DIV,
      CMD_SETUP_POW,
      CMD_POW_STEP,
      CMD_SETUP_CATMUL,
      CMD_MUL_STEP,
      CMD_DIV_STEP,
      CMD_FINISH
   } csia_cmd_type;

   // datapath status towards the controller
   typedef struct packed {
      logic [2:0] operation;
      logic       pow_more;
      logic       k_ovf;
      logic       cat_bad;
   } csia_stat_type;

   // unsigned magnitude of a two's complement word
   function automatic logic [63:0] mag64(input logic [63:0] x);
      mag64 = x[63] ? (~x + 64'd1) : x;
   endfunction

endpackage

FILE: rtl/csia_ctrl.sv
// controller state machine of the checked signed integer alu
module csia_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  csia_pkg::csia_stat_type stat,
   output csia_pkg::csia_cmd_type  cmd,
   output logic                   busy
);
   import csia_pkg::*;

   csia_state_type state_ff, state_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic           last_step;

   assign last_step = (cnt_ff == 6'(StepCount - 1));
   assign busy      = (state_ff != S_IDLE);

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            cnt_in = '0;
            unique case (stat.operation)
               OP_MUL: state_in = S_MUL;
               OP_DIV, OP_MOD: state_in = S_DIV;
               OP_CAT: state_in = stat.cat_bad ? S_FINISH : S_POW;
               default: state_in = S_FINISH;
            endcase
         end
         S_POW: begin
            if (!stat.pow_more) state_in = stat.k_ovf ? S_FINISH : S_MUL;
         end
         S_MUL, S_DIV: begin
            cnt_in = cnt_ff + 6'd1;
            if (last_step) state_in = S_FINISH;
         end
         S_FINISH: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) cmd = CMD_LOAD;
         end
         S_DISPATCH: begin
            unique case (stat.operation)
               OP_MUL: cmd = CMD_SETUP_MUL;
               OP_DIV, OP_MOD: cmd = CMD_SETUP_DIV;
               OP_CAT: cmd = stat.cat_bad ? CMD_NONE : CMD_SETUP_POW;
               default: cmd = CMD_NONE;
            endcase
         end
         S_POW: begin
            if (stat.pow_more) cmd = CMD_POW_STEP;
            else if (!stat.k_ovf) cmd = CMD_SETUP_CATMUL;
         end
         S_MUL:    cmd = CMD_MUL_STEP;
         S_DIV:    cmd = CMD_DIV_STEP;
         S_FINISH: cmd = CMD_FINISH;
         default:  cmd = CMD_NONE;
      endcase
   end

endmodule

FILE: rtl/csia_dp.sv
// datapath: operand registers, power-of-ten register, shift-add multiplier, restoring divider, result checks
module csia_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  csia_pkg::csia_cmd_type  cmd,
   input  csia_pkg::csia_req_type  req_data,
   output csia_pkg::csia_stat_type stat,
   output logic                   rsp_valid,
   output csia_pkg::csia_rsp_type  rsp_data
);
   import csia_pkg::*;

   localparam logic [63:0] MinWord = 64'h8000_0000_0000_0000;
   localparam logic [63:0] AllOnes = '1;

   logic [2:0]   op_ff;
   logic [63:0]  a_ff, b_ff, mcand_ff, k_ff;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  mcand_in, k_in;
   logic         rsp_valid_ff;
   csia_rsp_type rsp_ff, rsp_in;

   logic [64:0]  mul_sum, div_diff;
   logic [63:0]  div_rem;
   logic [63:0]  hi, lo;

   // status towards the controller
   assign stat.operation = op_ff;
   assign stat.pow_more  = (k_ff <= b_ff);
   assign stat.k_ovf     = k_ff[63];
   assign stat.cat_bad   = a_ff[63] || (a_ff == '0) || b_ff[63];

   assign hi = acc_ff[127:64];
   assign lo = acc_ff[63:0];

   // one multiply and one divide step
   assign mul_sum  = {1'b0, hi} + (lo[0] ? {1'b0, mcand_ff} : 65'd0);
   assign div_rem  = {hi[62:0], lo[63]};
   assign div_diff = {1'b0, div_rem} - {1'b0, mcand_ff};

   // working registers
   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      k_in     = k_ff;
      unique case (cmd)
         CMD_SETUP_MUL: begin
            acc_in   = {64'd0, mag64(b_ff)};
            mcand_in = mag64(a_ff);
         end
         CMD_SETUP_DIV: begin
            acc_in   = {64'd0, mag64(a_ff)};
            mcand_in = mag64(b_ff);
         end
         CMD_SETUP_POW:    k_in = 64'd10;
         CMD_POW_STEP:     k_in = (k_ff << 3) + (k_ff << 1);
         CMD_SETUP_CATMUL: begin
            acc_in   = {64'd0, k_ff};
            mcand_in = a_ff;
         end
         CMD_MUL_STEP: acc_in = {mul_sum, lo[63:1]};
         CMD_DIV_STEP: begin
            if (!div_diff[64]) acc_in = {div_diff[63:0], lo[62:0], 1'b1};
            else               acc_in = {div_rem, lo[62:0], 1'b0};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD) begin
         op_ff <= req_data.operation;
         a_ff  <= req_data.operand_a;
         b_ff  <= req_data.operand_b;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      k_ff     <= k_in;
   end

   // final checks and result selection
   always_comb begin
      logic [63:0] sum, dif, q, rm, csum, val;
      logic        neg;
      csia_status_type st;
      sum  = a_ff + b_ff;
      dif  = a_ff - b_ff;
      csum = lo + b_ff;
      neg  = a_ff[63] ^ b_ff[63];
      q    = neg ? (~lo + 64'd1) : lo;
      rm   = hi;
      val  = '0;
      st   = ST_OK;
      unique case (op_ff)
         OP_ADD: begin
            if (!(a_ff[63] ^ b_ff[63]) && (sum[63] ^ a_ff[63])) st = ST_OVERFLOW;
            val = sum;
         end
         OP_SUB: begin
            if ((a_ff[63] ^ b_ff[63]) && (dif[63] ^ a_ff[63])) st = ST_OVERFLOW;
            val = dif;
         end
         OP_MUL: begin
            if (hi != '0) st = ST_OVERFLOW;
            else if (neg ? (lo > MinWord) : lo[63]) st = ST_OVERFLOW;
            val = neg ? (~lo + 64'd1) : lo;
         end
         OP_DIV: begin
            if (b_ff == '0) st = ST_DIV_ZERO;
            else if (a_ff == MinWord && b_ff == AllOnes) st = ST_OVERFLOW;
            val = q;
         end
         OP_MOD: begin
            if (b_ff == '0) st = ST_DIV_ZERO;
            else if (b_ff == AllOnes) val = '0;
            else if (a_ff[63] && rm != '0) val = mcand_ff - rm;
            else val = rm;
         end
         OP_CAT: begin
            if (stat.cat_bad) st = ST_INVALID;
            else if (k_ff[63]) st = ST_OVERFLOW;
            else if (hi != '0 || lo[63]) st = ST_OVERFLOW;
            else if (csum[63]) st = ST_OVERFLOW;
            val = csum;
         end
         default: st = ST_INVALID;
      endcase
      rsp_in.status       = st;
      rsp_in.result_value = (st == ST_OK) ? val : '0;
   end

   // result register, shown for one cycle
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= (cmd == CMD_FINISH);
      if (cmd == CMD_FINISH) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/checked_signed_integer_alu.sv
// top level of the checked signed integer alu
//
// one transaction: pulse start with req_data while busy is low; the operation
// and both 64-bit signed operands are captured and busy rises the next cycle.
// the result appears on rsp_data for exactly one cycle with rsp_valid high,
// in the cycle busy falls; the receiver cannot hold it off.
// path from the accepting edge to the result cycle:
//   add, subtract, unused codes: dispatch, then finish
//   multiply, divide, modulo: dispatch, 64 steps of the shared shift-add /
//   restoring unit, one bit per cycle, then finish
//   concatenate: dispatch, power-of-ten steps while the power is at most b,
//   then 64 multiply steps and finish; straight to finish once the power of
//   ten leaves the signed range, or after dispatch for a bad operand
// a new transaction is taken in the cycle the result is shown.
// synchronous reset clears the controller to idle and drops rsp_valid;
// a transaction in flight is lost.
module checked_signed_integer_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  csia_pkg::csia_req_type req_data,
   output logic                  rsp_valid,
   output csia_pkg::csia_rsp_type rsp_data
);
   import csia_pkg::*;

   csia_cmd_type  cmd;
   csia_stat_type stat;

   csia_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   csia_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/csia_checker.sv
// port-level assertions for the checked signed integer alu
module csia_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input csia_pkg::csia_rsp_type rsp_data
);
   import csia_pkg::*;

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accept");

   // the result strobe lasts one cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("rsp_valid held");

   // the end of busy comes with the result
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy fell without result");

   // a failed status carries a zero value
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.result_value == '0)
      else $error("non-zero value with error status");

   // no result in the cycle after an accept
   a_req_seen: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid) else $error("result right after accept");

endmodule

bind checked_signed_integer_alu csia_checker u_csia_checker (.*);
